### hw/rtl/obrb_pkg.sv
// Shared types and codes for the overwriting byte ring buffer.
`timescale 1ns / 1ps
`default_nettype none
package obrb_pkg;

  // Request codes as they arrive on req_type_i.
  localparam logic [2:0] REQ_WRITE   = 3'd0;
  localparam logic [2:0] REQ_READ    = 3'd1;
  localparam logic [2:0] REQ_PEEK    = 3'd2;
  localparam logic [2:0] REQ_DISCARD = 3'd3;
  localparam logic [2:0] REQ_CLEAR   = 3'd4;

  // Field widths fixed by the block's interface.
  localparam int unsigned CAP_W   = 9;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned AMT_W   = 7;
  localparam int unsigned DROP_W  = 32;

  // Operation after classification in the front end.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_WRITE,
    OP_READ,
    OP_PEEK,
    OP_DISCARD,
    OP_CLEAR
  } op_e;

  // One classified request as it travels through the command queue.
  typedef struct packed {
    op_e               op;
    logic [BYTE_W-1:0] data;
    logic [AMT_W-1:0]  amt;
  } cmd_t;

  // One result as driven onto the output ports.
  typedef struct packed {
    logic              strobe;
    logic              data_valid;
    logic              last;
    logic [AMT_W-1:0]  count;
    logic [CAP_W-1:0]  fill;
    logic [DROP_W-1:0] drop;
  } res_t;

endpackage
`default_nettype wire

### hw/rtl/obrb_front.sv
// Front end: decodes and classifies incoming requests into queue commands.
`timescale 1ns / 1ps
`default_nettype none
module obrb_front #(
  parameter int unsigned MAX_BURST = 64
) (
  input  wire logic [2:0]  req_type_i,
  input  wire logic [7:0]  data_in_i,
  input  wire logic [6:0]  amount_i,
  input  wire logic        cap_zero_i,
  output obrb_pkg::cmd_t   cmd_o
);
  import obrb_pkg::*;

  localparam logic [AMT_W-1:0] BURST_LIM = AMT_W'(MAX_BURST);

  op_e op;

  // Map the request code to an operation; a disabled ring turns all into no-ops.
  always_comb begin
    case (req_type_i)
      REQ_WRITE:   op = OP_WRITE;
      REQ_READ:    op = OP_READ;
      REQ_PEEK:    op = OP_PEEK;
      REQ_DISCARD: op = OP_DISCARD;
      REQ_CLEAR:   op = OP_CLEAR;
      default:     op = OP_NOP;
    endcase
    if (cap_zero_i) begin
      op = OP_NOP;
    end
  end

  // Saturate the burst length to the largest supported burst.
  always_comb begin
    cmd_o.op   = op;
    cmd_o.data = data_in_i;
    cmd_o.amt  = (amount_i > BURST_LIM) ? BURST_LIM : amount_i;
  end

endmodule
`default_nettype wire

### hw/rtl/obrb_queue.sv
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module obrb_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire obrb_pkg::cmd_t push_cmd_i,
  output logic                full_o,
  output logic                valid_o,
  output obrb_pkg::cmd_t      cmd_o,
  input  wire logic           pop_i
);
  import obrb_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = slot_q[rd_ptr_q];

  // Pointer and occupancy update; a push and a pop may share a cycle.
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/obrb_back.sv
// Back end: ring state, byte memory and result generation.
`timescale 1ns / 1ps
`default_nettype none
module obrb_back #(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           clear_i,
  input  wire logic [8:0]     cap_i,
  input  wire logic           cmd_valid_i,
  input  wire obrb_pkg::cmd_t cmd_i,
  output logic                cmd_pop_o,
  output obrb_pkg::res_t      res_o,
  output logic [7:0]          data_byte_o
);
  import obrb_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  // Sum width for index arithmetic; indices stay below the capacity.
  localparam int unsigned SW = ((AW > CAP_W) ? AW : CAP_W) + 1;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_STREAM = 1'b1;

  logic [BYTE_W-1:0] mem_q [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  logic              st_q, st_d;
  logic [AW-1:0]     head_q, head_d;
  logic [AW-1:0]     tail_q, tail_d;
  logic [AW-1:0]     rd_idx_q, rd_idx_d;
  logic [CAP_W-1:0]  fill_q, fill_d;
  logic [DROP_W-1:0] drop_q, drop_d;
  logic [AMT_W-1:0]  remain_q, remain_d;
  logic [AMT_W-1:0]  cnt_q, cnt_d;
  res_t              res_q, res_d;

  logic [AMT_W-1:0]  n;
  logic [SW-1:0]     cap_ext;
  logic [SW-1:0]     head_sum;
  logic [AW-1:0]     head_adv;
  logic [AW-1:0]     head_inc;
  logic [AW-1:0]     tail_inc;
  logic [AW-1:0]     rd_inc;
  logic              wr_en;
  logic              rd_en;
  logic              full;

  // Bytes a read, peek or discard can take: the smaller of fill and burst.
  assign n = (fill_q < {{(CAP_W-AMT_W){1'b0}}, cmd_i.amt}) ? fill_q[AMT_W-1:0] : cmd_i.amt;

  // Index steps wrap at the capacity; a sum stays below twice the capacity.
  assign cap_ext  = SW'(cap_i);
  assign head_sum = SW'(head_q) + SW'(n);
  assign head_adv = (head_sum >= cap_ext) ? AW'(head_sum - cap_ext) : AW'(head_sum);
  assign head_inc = (SW'(head_q) + SW'(1) == cap_ext) ? '0 : head_q + AW'(1);
  assign tail_inc = (SW'(tail_q) + SW'(1) == cap_ext) ? '0 : tail_q + AW'(1);
  assign rd_inc   = (SW'(rd_idx_q) + SW'(1) == cap_ext) ? '0 : rd_idx_q + AW'(1);
  assign full     = (fill_q >= cap_i);

  assign cmd_pop_o = cmd_valid_i && (st_q == ST_IDLE);

  // Execute one command per idle cycle, or stream one byte per cycle.
  always_comb begin
    st_d     = st_q;
    head_d   = head_q;
    tail_d   = tail_q;
    rd_idx_d = rd_idx_q;
    fill_d   = fill_q;
    drop_d   = drop_q;
    remain_d = remain_q;
    cnt_d    = cnt_q;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    res_d    = '0;

    case (st_q)
      ST_IDLE: begin
        if (cmd_pop_o) begin
          res_d.strobe = 1'b1;
          res_d.last   = 1'b1;
          case (cmd_i.op)
            OP_WRITE: begin
              wr_en  = 1'b1;
              tail_d = tail_inc;
              if (full) begin
                // Oldest byte is overwritten and counted as dropped.
                head_d = head_inc;
                if (drop_q != '1) begin
                  drop_d = drop_q + DROP_W'(1);
                end
              end else begin
                fill_d = fill_q + CAP_W'(1);
              end
              res_d.count = AMT_W'(1);
            end
            OP_CLEAR: begin
              head_d = '0;
              tail_d = '0;
              fill_d = '0;
              drop_d = '0;
            end
            OP_DISCARD: begin
              head_d      = head_adv;
              fill_d      = fill_q - CAP_W'(n);
              res_d.count = n;
            end
            OP_READ, OP_PEEK: begin
              if (n != '0) begin
                // The byte results come from the stream state.
                res_d.strobe = 1'b0;
                st_d         = ST_STREAM;
                rd_idx_d     = head_q;
                remain_d     = n;
                cnt_d        = n;
                if (cmd_i.op == OP_READ) begin
                  head_d = head_adv;
                  fill_d = fill_q - CAP_W'(n);
                end
              end
            end
            default: begin
            end
          endcase
          res_d.fill = fill_d;
          res_d.drop = drop_d;
        end
      end
      ST_STREAM: begin
        rd_en            = 1'b1;
        rd_idx_d         = rd_inc;
        remain_d         = remain_q - AMT_W'(1);
        res_d.strobe     = 1'b1;
        res_d.data_valid = 1'b1;
        res_d.last       = (remain_q == AMT_W'(1));
        res_d.count      = cnt_q;
        res_d.fill       = fill_q;
        res_d.drop       = drop_q;
        if (remain_q == AMT_W'(1)) begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase

    // A capacity write empties the ring.
    if (clear_i) begin
      st_d   = ST_IDLE;
      head_d = '0;
      tail_d = '0;
      fill_d = '0;
      drop_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      rd_idx_q <= '0;
      fill_q   <= '0;
      drop_q   <= '0;
      remain_q <= '0;
      cnt_q    <= '0;
      res_q    <= '0;
    end else begin
      st_q     <= st_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      rd_idx_q <= rd_idx_d;
      fill_q   <= fill_d;
      drop_q   <= drop_d;
      remain_q <= remain_d;
      cnt_q    <= cnt_d;
      res_q    <= res_d;
    end
  end

  // Byte memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[tail_q] <= cmd_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_idx_q];
    end
  end

  assign res_o       = res_q;
  assign data_byte_o = res_q.data_valid ? rdata_q : '0;

endmodule
`default_nettype wire

### hw/rtl/overwriting_byte_ring_buffer_core.sv
// Top level of the overwriting byte ring buffer.
//
// Requests enter on start/busy: a request transfers at a rising edge with start
// high and busy low. The front end classifies it and places it in a two-entry
// command queue; busy is high only while that queue is full.
// Results leave on result_strobe_o, one per cycle at most, and the receiver
// cannot stall them. A read or peek of n > 0 bytes yields n byte results on
// consecutive cycles after a back-end dispatch step; any other request yields
// one registered result. Throughput: one single-result request per cycle while
// the back end is idle; a read or peek of n bytes holds the back end for a
// dispatch step, then one byte per cycle on the single memory read port. The
// capacity register must be written through cfg_we_i/cfg_wdata_i only while
// the block is idle, which the block does not enforce; each write empties the
// ring and zeroes the drop count. Reset empties the ring, zeroes the drop count
// and sets the capacity to CAP_MAX. The byte memory is not cleared; only bytes
// inside the fill level are read.
`timescale 1ns / 1ps
`default_nettype none
module overwriting_byte_ring_buffer_core #(
  parameter int unsigned DEPTH     = 256,
  parameter int unsigned MAX_BURST = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [7:0]  data_in_i,
  input  wire logic [6:0]  amount_i,
  input  wire logic        cfg_we_i,
  input  wire logic [8:0]  cfg_wdata_i,
  output logic             result_strobe_o,
  output logic [7:0]       data_byte_o,
  output logic             data_valid_o,
  output logic             last_byte_o,
  output logic [6:0]       count_done_o,
  output logic [8:0]       fill_level_o,
  output logic [31:0]      dropped_total_o
);
  import obrb_pkg::*;

  // Largest usable capacity that the register and the memory both allow.
  localparam int unsigned CAP_LIM = (DEPTH < 511) ? DEPTH : 511;
  localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(CAP_LIM);

  logic [CAP_W-1:0] cap_q, cap_d;
  cmd_t             front_cmd;
  cmd_t             queue_cmd;
  logic             queue_full;
  logic             queue_valid;
  logic             queue_pop;
  logic             push;
  res_t             res;

  assign push = start && !busy;
  assign busy = queue_full;

  // Capacity register, saturated to the largest usable capacity when written.
  assign cap_d = (cfg_wdata_i > CAP_MAX) ? CAP_MAX : cfg_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_MAX;
    end else if (cfg_we_i) begin
      cap_q <= cap_d;
    end
  end

  obrb_front #(
    .MAX_BURST (MAX_BURST)
  ) u_front (
    .req_type_i (req_type_i),
    .data_in_i  (data_in_i),
    .amount_i   (amount_i),
    .cap_zero_i (cap_q == '0),
    .cmd_o      (front_cmd)
  );

  obrb_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (front_cmd),
    .full_o     (queue_full),
    .valid_o    (queue_valid),
    .cmd_o      (queue_cmd),
    .pop_i      (queue_pop)
  );

  obrb_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (cfg_we_i),
    .cap_i       (cap_q),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (queue_pop),
    .res_o       (res),
    .data_byte_o (data_byte_o)
  );

  // Result ports.
  assign result_strobe_o = res.strobe;
  assign data_valid_o    = res.data_valid;
  assign last_byte_o     = res.last;
  assign count_done_o    = res.count;
  assign fill_level_o    = res.fill;
  assign dropped_total_o = res.drop;

endmodule
`default_nettype wire
